// File: design/admm_terminal_vector_update_top_defines.svh
// assertion helpers for the terminal vector update block
// both sample on clk_i and are disabled while rst_ni is low
`ifndef ADMM_TERMINAL_VECTOR_UPDATE_TOP_DEFINES_SVH
`define ADMM_TERMINAL_VECTOR_UPDATE_TOP_DEFINES_SVH

// same-cycle implication
`define ATVU_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("atvu: same-cycle check failed");

// next-cycle implication
`define ATVU_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("atvu: next-cycle check failed");

`endif

// File: design/atvu_pkg.sv
`timescale 1ns / 1ps
package atvu_pkg;

  localparam int unsigned IDX_W = 6;

  typedef enum logic [1:0] {
    KIND_LOAD       = 2'd0,
    KIND_UPDATE     = 2'd1,
    KIND_SCALE      = 2'd2,
    KIND_SCALE_COPY = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   index;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic               first;
  } in_req_t;

  typedef struct packed {
    logic signed [31:0] out_value;
    logic [63:0]        primal_sum;
    logic [63:0]        dual_sum;
  } out_rsp_t;

  // one row of the element store, all Q16.16
  typedef struct packed {
    logic signed [31:0] power;
    logic signed [31:0] pdual;
    logic signed [31:0] angle;
    logic signed [31:0] adual;
    logic signed [31:0] ppower;
    logic signed [31:0] pangle;
  } row_t;

  // squared residuals and copy-out operands handed to the accumulate stage
  typedef struct packed {
    logic               hit;
    kind_e              kind;
    logic               first;
    logic [63:0]        sq_dp;
    logic [63:0]        sq_dt;
    logic [63:0]        sq_pb;
    logic [63:0]        sq_th;
    logic signed [31:0] power;
    logic signed [31:0] pdual;
  } stage_t;

  // saturate to the signed 32-bit range
  function automatic logic signed [31:0] clamp_s32(input logic signed [47:0] x);
    logic signed [31:0] r;
    if (x[47:31] == '0 || x[47:31] == '1) begin
      r = x[31:0];
    end else if (x[47]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// File: design/atvu_ram.sv
`timescale 1ns / 1ps
module atvu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/atvu_exec.sv
`timescale 1ns / 1ps
module atvu_exec (
  input  atvu_pkg::in_req_t req_i,
  input  atvu_pkg::row_t    row_i,
  input  logic              hit_i,
  output atvu_pkg::row_t    row_o,
  output atvu_pkg::stage_t  stage_o
);
  import atvu_pkg::*;

  logic               upd;
  logic signed [33:0] d_dp, d_dt, d_th, d_pb;
  logic signed [33:0] m_dp, m_dt, m_th, m_pb;
  logic signed [33:0] s_pd, s_ad, s_pp;
  logic signed [32:0] mul_a [4];
  logic signed [32:0] mul_b [4];
  logic signed [65:0] prod  [4];

  // magnitude of a difference, saturated square when it reaches 2^32
  function automatic logic [63:0] sq_sat(input logic signed [33:0] m,
                                         input logic signed [65:0] p);
    return (m[33:32] != 2'b00) ? '1 : p[63:0];
  endfunction

  always_comb begin
    upd  = (req_i.kind == KIND_UPDATE);
    d_dp = 34'(row_i.power) - 34'(row_i.ppower) - 34'(req_i.value_a);
    d_dt = 34'(req_i.value_b) - 34'(row_i.pangle);
    d_th = 34'(row_i.angle) - 34'(req_i.value_b);
    d_pb = 34'(req_i.value_a);
    m_dp = d_dp[33] ? -d_dp : d_dp;
    m_dt = d_dt[33] ? -d_dt : d_dt;
    m_th = d_th[33] ? -d_th : d_th;
    m_pb = d_pb[33] ? -d_pb : d_pb;

    // lanes 0 and 1 are shared between residual squares and dual scaling
    mul_a[0] = upd ? {1'b0, m_dp[31:0]} : 33'(row_i.pdual);
    mul_b[0] = upd ? {1'b0, m_dp[31:0]} : 33'(req_i.value_a);
    mul_a[1] = upd ? {1'b0, m_dt[31:0]} : 33'(row_i.adual);
    mul_b[1] = upd ? {1'b0, m_dt[31:0]} : 33'(req_i.value_a);
    mul_a[2] = {1'b0, m_pb[31:0]};
    mul_b[2] = {1'b0, m_pb[31:0]};
    mul_a[3] = {1'b0, m_th[31:0]};
    mul_b[3] = {1'b0, m_th[31:0]};
    for (int k = 0; k < 4; k++) begin
      prod[k] = mul_a[k] * mul_b[k];
    end

    s_pd = 34'(row_i.pdual) + 34'(req_i.value_a);
    s_ad = 34'(row_i.adual) + d_th;
    s_pp = 34'(row_i.power) - 34'(req_i.value_a);

    row_o = row_i;
    case (req_i.kind)
      KIND_LOAD: begin
        row_o.power = req_i.value_a;
      end
      KIND_UPDATE: begin
        row_o.pdual  = clamp_s32(48'(s_pd));
        row_o.ppower = clamp_s32(48'(s_pp));
        row_o.power  = clamp_s32(48'(s_pp));
        row_o.adual  = clamp_s32(48'(s_ad));
        row_o.pangle = row_i.angle;
        row_o.angle  = req_i.value_b;
      end
      KIND_SCALE, KIND_SCALE_COPY: begin
        // floor shift by 16, product always fits in 64 bits
        row_o.pdual = clamp_s32($signed(prod[0][63:16]));
        row_o.adual = clamp_s32($signed(prod[1][63:16]));
      end
      default: begin
        row_o = row_i;
      end
    endcase

    stage_o.hit   = hit_i;
    stage_o.kind  = req_i.kind;
    stage_o.first = req_i.first;
    stage_o.sq_dp = sq_sat(m_dp, prod[0]);
    stage_o.sq_dt = sq_sat(m_dt, prod[1]);
    stage_o.sq_pb = sq_sat(m_pb, prod[2]);
    stage_o.sq_th = sq_sat(m_th, prod[3]);
    stage_o.power = row_i.power;
    stage_o.pdual = row_o.pdual;
  end

endmodule

// File: design/atvu_accum.sv
`timescale 1ns / 1ps
module atvu_accum (
  input  atvu_pkg::stage_t  stage_i,
  input  logic [63:0]       primal_i,
  input  logic [63:0]       dual_i,
  output atvu_pkg::out_rsp_t rsp_o
);
  import atvu_pkg::*;

  logic               upd;
  logic [63:0]        base_p, base_d;
  logic [65:0]        sum_p, sum_d;
  logic signed [33:0] diff;

  always_comb begin
    upd    = stage_i.hit && (stage_i.kind == KIND_UPDATE);
    base_p = (upd && stage_i.first) ? '0 : primal_i;
    base_d = (upd && stage_i.first) ? '0 : dual_i;
    // operands are nonnegative, so one saturation after the full sum suffices
    sum_p  = 66'(base_p) + 66'(stage_i.sq_pb) + 66'(stage_i.sq_th);
    sum_d  = 66'(base_d) + 66'(stage_i.sq_dp) + 66'(stage_i.sq_dt);
    diff   = 34'(stage_i.power) - 34'(stage_i.pdual);

    rsp_o.primal_sum = primal_i;
    rsp_o.dual_sum   = dual_i;
    if (upd) begin
      rsp_o.primal_sum = (sum_p[65:64] != 2'b00) ? '1 : sum_p[63:0];
      rsp_o.dual_sum   = (sum_d[65:64] != 2'b00) ? '1 : sum_d[63:0];
    end
    rsp_o.out_value = (stage_i.hit && stage_i.kind == KIND_SCALE_COPY) ?
                      clamp_s32(48'(diff)) : '0;
  end

endmodule

// File: design/admm_terminal_vector_update_top.sv
// flow: a request is read and executed in stage 1, accumulated in stage 2, then registered at the output
// throughput: one request per cycle unless out_stall_i backs up; the store is read-modify-write
//   with a one-deep bypass, and the residual accumulators close their loop in the last stage
// reset: rst_ni asynchronous active low; clears pipeline valids, accumulators and
//   per-row valid bits, so every element reads as zero until written; no sweep
`timescale 1ns / 1ps
`include "admm_terminal_vector_update_top_defines.svh"
module admm_terminal_vector_update_top #(
  parameter int unsigned MAX_TERMS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  atvu_pkg::in_req_t   in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output atvu_pkg::out_rsp_t  out_rsp_o
);
  import atvu_pkg::*;

  // index is only 6 bits wide, so no more rows can ever be addressed
  localparam int unsigned SPAN  = 1 << IDX_W;
  localparam int unsigned DEPTH = (MAX_TERMS < SPAN) ? MAX_TERMS : SPAN;
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ROW_W = $bits(row_t);

  // pipeline control
  logic s1_v_q, s2_v_q, out_v_q;
  logic out_free, s1_free, s1_adv, s2_adv, in_acc;

  // stage 1: request, bypass and row valid captured with the read
  in_req_t s1_q;
  logic    hit_q, rdv_q;
  row_t    fwd_q;
  row_t    row_eff, row_wr;
  logic    s1_hit;

  // stage 2 and output
  stage_t   stage_d, s2_q;
  out_rsp_t rsp_d, out_q;
  logic [63:0] primal_acc_q, dual_acc_q;

  // row store
  logic [DEPTH-1:0] vld_q;
  logic             ram_we;
  logic [AW-1:0]    waddr, raddr;
  logic [ROW_W-1:0] ram_rdata;

  // stalls ripple back only when every stage is full
  assign out_free   = !out_v_q || !out_stall_i;
  assign s1_free    = !s2_v_q || out_free;
  assign s1_adv     = s1_v_q && s1_free;
  assign s2_adv     = s2_v_q && out_free;
  assign in_stall_o = s1_v_q && !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // out-of-range index leaves everything untouched
  assign s1_hit = (32'(s1_q.index) < 32'(MAX_TERMS));
  assign ram_we = s1_adv && s1_hit;
  assign waddr  = s1_q.index[AW-1:0];
  assign raddr  = in_req_i.index[AW-1:0];

  atvu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (waddr),
    .wdata_i (row_wr),
    .re_i    (in_acc),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  // the row written at the read edge wins; an unwritten row reads as zero
  assign row_eff = hit_q ? fwd_q : (rdv_q ? row_t'(ram_rdata) : '0);

  atvu_exec u_exec (
    .req_i   (s1_q),
    .row_i   (row_eff),
    .hit_i   (s1_hit),
    .row_o   (row_wr),
    .stage_o (stage_d)
  );

  atvu_accum u_accum (
    .stage_i  (s2_q),
    .primal_i (primal_acc_q),
    .dual_i   (dual_acc_q),
    .rsp_o    (rsp_d)
  );

  // control and accumulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      out_v_q      <= 1'b0;
      vld_q        <= '0;
      primal_acc_q <= '0;
      dual_acc_q   <= '0;
    end else begin
      if (in_acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv) begin
        out_v_q      <= 1'b1;
        primal_acc_q <= rsp_d.primal_sum;
        dual_acc_q   <= rsp_d.dual_sum;
      end else if (!out_stall_i) begin
        out_v_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[waddr] <= 1'b1;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q  <= in_req_i;
      hit_q <= ram_we && (waddr == raddr);
      fwd_q <= row_wr;
      rdv_q <= vld_q[raddr];
    end
    if (s1_adv) begin
      s2_q <= stage_d;
    end
    if (s2_adv) begin
      out_q <= rsp_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

  // input only backs up when all three stages hold requests
  `ATVU_ASSERT_IMP(a_stall_full, in_stall_o, s1_v_q && s2_v_q && out_v_q)
  // accumulators only move on an in-range update
  `ATVU_ASSERT_NXT(a_acc_hold,
    !(s2_adv && s2_q.hit && s2_q.kind == KIND_UPDATE),
    $stable(primal_acc_q) && $stable(dual_acc_q))
  // a new result always comes from the accumulate stage
  `ATVU_ASSERT_IMP(a_out_src, $rose(out_v_q), $past(s2_v_q))

endmodule
